// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the nearest centroid search block.
// The including module must have a clock named clk and a reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define NCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define NCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ncs_pkg.sv -----
// Package of the nearest centroid search block: default sizes, width helpers,
// register indexes and command codes. No dependencies.
`default_nettype none

package ncs_pkg;

	localparam int NCS_MAX_CENTROIDS = 16;
	localparam int NCS_COORD_BITS    = 16;
	localparam int NCS_MAX_DIMS      = 3;
	localparam int NCS_DIMS_W        = 2;
	localparam int NCS_CFG_IDX_W     = 1;

	localparam logic [NCS_DIMS_W-1:0] NCS_NUM_DIMS_RST = NCS_DIMS_W'(NCS_MAX_DIMS);

	typedef enum logic [NCS_CFG_IDX_W-1:0] {
		REG_NUM_CENTROIDS = 1'b0,
		REG_NUM_DIMS      = 1'b1
	} ncs_cfg_reg_t;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	function automatic int ncs_idx_width(input int max_centroids);
		return (max_centroids > 1) ? $clog2(max_centroids) : 1;
	endfunction

	function automatic int ncs_count_width(input int max_centroids);
		return $clog2(max_centroids + 1);
	endfunction

	function automatic int ncs_dist_width(input int coord_bits);
		return 2 * coord_bits + 2;
	endfunction

	function automatic int ncs_cfg_data_width(input int max_centroids);
		return (ncs_count_width(max_centroids) > NCS_DIMS_W) ?
			ncs_count_width(max_centroids) : NCS_DIMS_W;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ncs_ifs.sv -----
// Valid/ready channel interfaces of the nearest centroid search block:
// configuration writes, input items and results. Depends on ncs_pkg.
`default_nettype none

interface ncs_cfg_if import ncs_pkg::*; #(
	parameter int DATA_W = ncs_cfg_data_width(NCS_MAX_CENTROIDS)
) ();
	logic                     valid;
	logic                     ready;
	logic [NCS_CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface ncs_item_if import ncs_pkg::*; #(
	parameter int IDX_W      = ncs_idx_width(NCS_MAX_CENTROIDS),
	parameter int COORD_BITS = NCS_COORD_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [IDX_W-1:0]             centroid_index;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;

	modport source (output valid, output cmd, output centroid_index,
		output coord_x, output coord_y, output coord_z, input ready);
	modport sink   (input valid, input cmd, input centroid_index,
		input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface ncs_result_if import ncs_pkg::*; #(
	parameter int IDX_W  = ncs_idx_width(NCS_MAX_CENTROIDS),
	parameter int DIST_W = ncs_dist_width(NCS_COORD_BITS)
) ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  nearest_index;
	logic [DIST_W-1:0] nearest_distance_sq;

	modport source (output valid, output nearest_index, output nearest_distance_sq,
		input ready);
	modport sink   (input valid, input nearest_index, input nearest_distance_sq,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/nearest_centroid_search_top.sv -----
// Top level of the nearest centroid search block: a chain of centroid cells.
// Depends on ncs_pkg, the interfaces in ncs_ifs.sv and assert_macros.svh.
//
// Usage:
// The cfg channel writes num_centroids (index 0) and num_dims (index 1); it is
// always ready and must only be used while no item is in flight.
// Each beat on items is either a load (cmd 0), which stores the coordinates as
// centroid centroid_index, or a classify (cmd 1), which yields one beat on
// results with the nearest active centroid and its squared distance.
// Centroid i lives in cell i of the chain; every cell has three stages
// (difference, square, sum and compare), and loads travel down the chain in
// order with the points, so a classify sees exactly the loads before it.
// Throughput is one item per cycle while results is not stalled. Each input
// beat passes through the stages of every cell before its result beat.
// When results is stalled with a result pending, the whole chain holds and
// items.ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the chain and sets num_centroids to 1 and num_dims to 3. The
// centroid registers are not reset and must be loaded before they are used.
`default_nettype none

`include "assert_macros.svh"

module nearest_centroid_search_top import ncs_pkg::*; #(
	parameter int MAX_CENTROIDS = NCS_MAX_CENTROIDS,
	parameter int COORD_BITS    = NCS_COORD_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ncs_cfg_if.sink        cfg,
	ncs_item_if.sink       items,
	ncs_result_if.source   results
);

	localparam int C      = COORD_BITS;
	localparam int IDX_W  = ncs_idx_width(MAX_CENTROIDS);
	localparam int NC_W   = ncs_count_width(MAX_CENTROIDS);
	localparam int DIST_W = ncs_dist_width(COORD_BITS);
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int LAST   = MAX_CENTROIDS - 1;

	logic [NC_W-1:0]       num_centroids_q;
	logic [NCS_DIMS_W-1:0] num_dims_q;
	logic [2:0]            dim_use;
	logic                  en;

	logic                  cin_vld [MAX_CENTROIDS];
	logic                  cin_cmd [MAX_CENTROIDS];
	logic [IDX_W-1:0]      cin_idx [MAX_CENTROIDS];
	logic signed [C-1:0]   cin_pt  [MAX_CENTROIDS][3];
	logic [IDX_W-1:0]      cin_bi  [MAX_CENTROIDS];
	logic [DIST_W-1:0]     cin_bd  [MAX_CENTROIDS];

	logic signed [C-1:0]   cen_q   [MAX_CENTROIDS][3];

	logic                  vld_s1  [MAX_CENTROIDS];
	logic                  cmd_s1  [MAX_CENTROIDS];
	logic [IDX_W-1:0]      idx_s1  [MAX_CENTROIDS];
	logic signed [C-1:0]   pt_s1   [MAX_CENTROIDS][3];
	logic signed [C:0]     dx_s1   [MAX_CENTROIDS][3];
	logic [IDX_W-1:0]      bi_s1   [MAX_CENTROIDS];
	logic [DIST_W-1:0]     bd_s1   [MAX_CENTROIDS];

	logic                  vld_s2  [MAX_CENTROIDS];
	logic                  cmd_s2  [MAX_CENTROIDS];
	logic [IDX_W-1:0]      idx_s2  [MAX_CENTROIDS];
	logic signed [C-1:0]   pt_s2   [MAX_CENTROIDS][3];
	logic [SQ_W-1:0]       sq_s2   [MAX_CENTROIDS][3];
	logic [IDX_W-1:0]      bi_s2   [MAX_CENTROIDS];
	logic [DIST_W-1:0]     bd_s2   [MAX_CENTROIDS];

	logic                  vld_s3  [MAX_CENTROIDS];
	logic                  cmd_s3  [MAX_CENTROIDS];
	logic [IDX_W-1:0]      idx_s3  [MAX_CENTROIDS];
	logic signed [C-1:0]   pt_s3   [MAX_CENTROIDS][3];
	logic [IDX_W-1:0]      bi_s3   [MAX_CENTROIDS];
	logic [DIST_W-1:0]     bd_s3   [MAX_CENTROIDS];

	logic signed [2*C+1:0] prod    [MAX_CENTROIDS][3];
	logic [DIST_W-1:0]     dsum    [MAX_CENTROIDS];
	logic                  take    [MAX_CENTROIDS];
	logic                  wr      [MAX_CENTROIDS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_centroids_q <= NC_W'(1);
			num_dims_q      <= NCS_NUM_DIMS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_NUM_CENTROIDS: num_centroids_q <= cfg.data[NC_W-1:0];
				REG_NUM_DIMS:      num_dims_q      <= cfg.data[NCS_DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	assign dim_use[0] = 1'b1;
	assign dim_use[1] = (num_dims_q >= NCS_DIMS_W'(2));
	assign dim_use[2] = (num_dims_q >= NCS_DIMS_W'(3));

	assign en          = !results.valid || results.ready;
	assign items.ready = en;

	assign results.valid               = vld_s3[LAST] && (cmd_s3[LAST] == CMD_CLASSIFY);
	assign results.nearest_index       = bi_s3[LAST];
	assign results.nearest_distance_sq = bd_s3[LAST];

	for (genvar g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign cin_vld[g]   = items.valid;
			assign cin_cmd[g]   = items.cmd;
			assign cin_idx[g]   = items.centroid_index;
			assign cin_pt[g][0] = items.coord_x;
			assign cin_pt[g][1] = items.coord_y;
			assign cin_pt[g][2] = items.coord_z;
			assign cin_bi[g]    = '0;
			assign cin_bd[g]    = '0;
			assign take[g]      = 1'b1;
		end else begin : g_link
			assign cin_vld[g] = vld_s3[g-1];
			assign cin_cmd[g] = cmd_s3[g-1];
			assign cin_idx[g] = idx_s3[g-1];
			assign cin_bi[g]  = bi_s3[g-1];
			assign cin_bd[g]  = bd_s3[g-1];
			for (genvar d = 0; d < 3; d++) begin : g_pt
				assign cin_pt[g][d] = pt_s3[g-1][d];
			end
			assign take[g] = (NC_W'(g) < num_centroids_q) && (dsum[g] < bd_s2[g]);
		end

		assign wr[g] = cin_vld[g] && (cin_cmd[g] == CMD_LOAD) &&
			(cin_idx[g] == IDX_W'(g));

		assign dsum[g] = DIST_W'(sq_s2[g][0]) + DIST_W'(sq_s2[g][1]) +
			DIST_W'(sq_s2[g][2]);

		for (genvar d = 0; d < 3; d++) begin : g_dim
			assign prod[g][d] = dx_s1[g][d] * dx_s1[g][d];

			always_ff @(posedge clk) begin
				if (en && wr[g]) begin
					cen_q[g][d] <= cin_pt[g][d];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					pt_s1[g][d] <= cin_pt[g][d];
					dx_s1[g][d] <= $signed({cin_pt[g][d][C-1], cin_pt[g][d]}) -
						$signed({cen_q[g][d][C-1], cen_q[g][d]});
					pt_s2[g][d] <= pt_s1[g][d];
					sq_s2[g][d] <= dim_use[d] ? prod[g][d][SQ_W-1:0] : '0;
					pt_s3[g][d] <= pt_s2[g][d];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[g] <= 1'b0;
				vld_s2[g] <= 1'b0;
				vld_s3[g] <= 1'b0;
			end else if (en) begin
				vld_s1[g] <= cin_vld[g];
				vld_s2[g] <= vld_s1[g];
				vld_s3[g] <= vld_s2[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cmd_s1[g] <= cin_cmd[g];
				idx_s1[g] <= cin_idx[g];
				bi_s1[g]  <= cin_bi[g];
				bd_s1[g]  <= cin_bd[g];
				cmd_s2[g] <= cmd_s1[g];
				idx_s2[g] <= idx_s1[g];
				bi_s2[g]  <= bi_s1[g];
				bd_s2[g]  <= bd_s1[g];
				cmd_s3[g] <= cmd_s2[g];
				idx_s3[g] <= idx_s2[g];
				bi_s3[g]  <= take[g] ? IDX_W'(g) : bi_s2[g];
				bd_s3[g]  <= take[g] ? dsum[g] : bd_s2[g];
			end
		end
	end

	`NCS_ASSERT_NOW(a_index_active, results.valid,
		(results.nearest_index == '0) || (NC_W'(results.nearest_index) < num_centroids_q),
		"nearest_index names an inactive centroid")
	`NCS_ASSERT_NOW(a_stall_blocks_input, results.valid && !results.ready, !items.ready,
		"input accepted while the result is stalled")
	`NCS_ASSERT_NEXT(a_bubble_follows, results.valid && results.ready && !vld_s2[LAST],
		!results.valid, "result repeated after it was taken")

endmodule

`default_nettype wire

// ----- sim/tb_nearest_centroid_search_top.sv -----
// Testbench for nearest_centroid_search_top: drives load and classify beats,
// predicts the nearest centroid and squared distance, and checks every result.
// Depends on ncs_pkg and the channel interfaces in ncs_ifs.sv.
`default_nettype none

module tb_nearest_centroid_search_top;
	import ncs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W         = ncs_idx_width(NCS_MAX_CENTROIDS);
	localparam int DIST_W        = ncs_dist_width(NCS_COORD_BITS);
	localparam int CFG_W         = ncs_cfg_data_width(NCS_MAX_CENTROIDS);
	localparam int SETTLE_CYCLES = 3 * NCS_MAX_CENTROIDS + 16;
	localparam int CYCLE_LIMIT   = 200000;

	typedef logic signed [NCS_COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dist_sq;
	} assignment_t;

	logic clk = 1'b0;
	logic arst_n;

	ncs_cfg_if    cfg_bus ();
	ncs_item_if   item_bus ();
	ncs_result_if result_bus ();

	nearest_centroid_search_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.items   (item_bus),
		.results (result_bus)
	);

	point_t            centroid_tab [NCS_MAX_CENTROIDS];
	logic [CFG_W-1:0]  model_num_centroids = CFG_W'(1);
	logic [1:0]        model_num_dims      = 2'd3;
	assignment_t       pending_assignments [$];
	int unsigned       mismatches = 0;
	int unsigned       cycle_count = 0;
	bit                tx_idle_en = 1'b1;
	bit                rx_idle_en = 1'b1;
	int                rx_hold_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic assignment_t nearest_centroid_of(point_t p);
		int          n;
		int          dims;
		longint      diff;
		longint      d;
		longint      best_d;
		int          best;
		coord_t      pc [3];
		coord_t      cc [3];
		assignment_t r;
		n = int'(model_num_centroids);
		if (n < 1) n = 1;
		if (n > NCS_MAX_CENTROIDS) n = NCS_MAX_CENTROIDS;
		dims = int'(model_num_dims);
		if (dims < 1) dims = 1;
		if (dims > NCS_MAX_DIMS) dims = NCS_MAX_DIMS;
		pc = '{p.x, p.y, p.z};
		best = 0;
		best_d = 0;
		for (int i = 0; i < n; i++) begin
			cc = '{centroid_tab[i].x, centroid_tab[i].y, centroid_tab[i].z};
			d = 0;
			for (int k = 0; k < dims; k++) begin
				diff = longint'(pc[k]) - longint'(cc[k]);
				d += diff * diff;
			end
			if (i == 0 || d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		r.idx = IDX_W'(best);
		r.dist_sq = DIST_W'(best_d);
		return r;
	endfunction

	always @(posedge clk) begin
		assignment_t exp_a;
		point_t      pt;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					REG_NUM_CENTROIDS: model_num_centroids = cfg_bus.data;
					REG_NUM_DIMS: model_num_dims = cfg_bus.data[1:0];
					default: ;
				endcase
			end
			if (item_bus.valid && item_bus.ready) begin
				pt = '{item_bus.coord_x, item_bus.coord_y, item_bus.coord_z};
				if (item_bus.cmd == CMD_LOAD) begin
					centroid_tab[item_bus.centroid_index] = pt;
				end else begin
					pending_assignments.insert(pending_assignments.size(),
						nearest_centroid_of(pt));
				end
			end
			if (result_bus.valid && result_bus.ready) begin
				if (pending_assignments.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result index %0d distance %0d", $time,
						result_bus.nearest_index, result_bus.nearest_distance_sq);
				end else begin
					exp_a = pending_assignments.pop_front();
					if (result_bus.nearest_index !== exp_a.idx) begin
						mismatches++;
						$display("%0t: nearest_index expected %0d actual %0d", $time,
							exp_a.idx, result_bus.nearest_index);
					end
					if (result_bus.nearest_distance_sq !== exp_a.dist_sq) begin
						mismatches++;
						$display("%0t: nearest_distance_sq expected %0d actual %0d", $time,
							exp_a.dist_sq, result_bus.nearest_distance_sq);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				result_bus.ready = 1'b0;
				rx_hold_cycles--;
			end else if (rx_idle_en) begin
				result_bus.ready = ($urandom_range(99) >= 10);
			end else begin
				result_bus.ready = 1'b1;
			end
		end
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return coord_t'(-32768);
					1: return coord_t'(32767);
					2: return coord_t'(0);
					default: return coord_t'(-1);
				endcase
			end
			1, 2: return coord_t'(int'($urandom_range(127)) - 64);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic send_item(logic cmd, logic [IDX_W-1:0] slot, coord_t x, coord_t y,
		coord_t z);
		@(negedge clk);
		while (tx_idle_en && $urandom_range(99) < 10) begin
			item_bus.valid = 1'b0;
			@(negedge clk);
		end
		item_bus.cmd = cmd;
		item_bus.centroid_index = slot;
		item_bus.coord_x = x;
		item_bus.coord_y = y;
		item_bus.coord_z = z;
		item_bus.valid = 1'b1;
		do @(posedge clk); while (!item_bus.ready);
	endtask

	task automatic load(int slot, int x, int y, int z);
		send_item(CMD_LOAD, IDX_W'(slot), coord_t'(x), coord_t'(y), coord_t'(z));
	endtask

	task automatic classify(int x, int y, int z);
		send_item(CMD_CLASSIFY, IDX_W'($urandom), coord_t'(x), coord_t'(y), coord_t'(z));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (pending_assignments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(ncs_cfg_reg_t r, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_bus.index = r;
		cfg_bus.data = value;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic configure(int n_centroids, int n_dims);
		wait_for_results();
		write_register(REG_NUM_CENTROIDS, CFG_W'(n_centroids));
		write_register(REG_NUM_DIMS, CFG_W'(n_dims));
	endtask

	task automatic random_traffic(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 20)
				load(int'($urandom_range(NCS_MAX_CENTROIDS - 1)), int'(rand_coord()),
					int'(rand_coord()), int'(rand_coord()));
			else
				classify(int'(rand_coord()), int'(rand_coord()), int'(rand_coord()));
		end
	endtask

	task automatic test_reset_defaults();
		load(0, -32768, -32768, -32768);
		classify(32767, 32767, 32767);
		classify(-32768, -32768, -32768);
	endtask

	task automatic test_load_table();
		load(0, -32768, -32768, -32768);
		load(1, 32767, 32767, 32767);
		load(2, 0, 0, 0);
		load(3, 0, 0, 0);
		for (int i = 4; i < NCS_MAX_CENTROIDS; i++)
			load(i, i * 3000 - 30000, 20000 - i * 2500, i * 97 - 700);
	endtask

	task automatic test_ties_and_limits();
		configure(16, 3);
		classify(0, 0, 0);
		classify(32767, 32767, 32767);
		classify(-32768, -32768, -32768);
		configure(16, 1);
		classify(0, 32767, -32768);
		configure(16, 2);
		classify(5, 5, 5);
		configure(0, 0);
		classify(1, 2, 3);
		configure(17, 3);
		classify(100, -100, 7);
		configure(31, 3);
		classify(-1, -1, -1);
	endtask

	task automatic test_random_settings();
		int n_centroids [6] = '{16, 31, 1, 7, 0, -1};
		int n_dims [6] = '{3, 1, 2, 0, 3, -1};
		for (int s = 0; s < 6; s++) begin
			configure(n_centroids[s] < 0 ? int'($urandom_range(31)) : n_centroids[s],
				n_dims[s] < 0 ? int'($urandom_range(3)) : n_dims[s]);
			random_traffic(45);
		end
	endtask

	task automatic test_no_idle();
		configure(16, 3);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		random_traffic(80);
		wait_for_results();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_hold_cycles = 200;
		random_traffic(60);
		wait_for_results();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_pause();
		random_traffic(15);
		wait_for_results();
		random_traffic(15);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_NUM_CENTROIDS;
		cfg_bus.data = '0;
		item_bus.valid = 1'b0;
		item_bus.cmd = CMD_LOAD;
		item_bus.centroid_index = '0;
		item_bus.coord_x = '0;
		item_bus.coord_y = '0;
		item_bus.coord_z = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_load_table();
		test_ties_and_limits();
		test_random_settings();
		test_no_idle();
		test_backpressure();
		test_pause();
		wait_for_results();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- nearest_centroid_search_top.f -----
+incdir+rtl
rtl/ncs_pkg.sv
rtl/ncs_ifs.sv
rtl/nearest_centroid_search_top.sv
sim/tb_nearest_centroid_search_top.sv
